@@ rtl/sbd_pkg.sv @@
// sparse byte diff codec: shared types and constants
// no dependencies; used by every module of the codec
package sbd_pkg;

    localparam int MAX_DIFFS_DEF       = 1024;
    localparam int MAX_FRAME_BYTES_DEF = 65536;
    localparam int POS_STORE_W         = 16;
    localparam int COUNT_OUT_W         = 11;

    typedef enum logic
    {
        ACT_ENCODE = 1'b0,
        ACT_APPLY  = 1'b1
    } action_t;

    typedef struct packed
    {
        action_t    action;
        logic [7:0] base_byte;
        logic [7:0] new_byte;
        logic       frame_end;
    } item_t;

    typedef struct packed
    {
        logic [7:0]             out_byte;
        logic                   byte_differs;
        logic [COUNT_OUT_W-1:0] diff_count;
        logic [COUNT_OUT_W-1:0] max_diff_count;
        logic                   overflow;
        logic                   frame_done;
    } result_t;

    typedef struct packed
    {
        logic [POS_STORE_W-1:0] position;
        logic [7:0]             value;
    } entry_t;

endpackage

@@ rtl/sbd_diff_mem.sv @@
// sparse byte diff codec: diff table memory, one write and one read port
// read data registered, valid in the cycle after the read address; depends on sbd_pkg
module sbd_diff_mem #(
    parameter int DEPTH = sbd_pkg::MAX_DIFFS_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               clk,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_idx,
    input  sbd_pkg::entry_t    wr_data,
    input  logic [IDX_W-1:0]   rd_idx,
    output sbd_pkg::entry_t    rd_data
);
    import sbd_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_idx];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/sbd_core.sv @@
// sparse byte diff codec: counters, compare, table update and head-entry prefetch
// depends on sbd_pkg; drives sbd_diff_mem
module sbd_core #(
    parameter int MAX_DIFFS       = sbd_pkg::MAX_DIFFS_DEF,
    parameter int MAX_FRAME_BYTES = sbd_pkg::MAX_FRAME_BYTES_DEF,
    parameter int IDX_W           = (MAX_DIFFS > 1) ? $clog2(MAX_DIFFS) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  sbd_pkg::item_t     item,
    output sbd_pkg::result_t   result,
    output logic               wr_en,
    output logic [IDX_W-1:0]   wr_idx,
    output sbd_pkg::entry_t    wr_data,
    output logic [IDX_W-1:0]   rd_idx,
    input  sbd_pkg::entry_t    rd_data
);
    import sbd_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIFFS + 1);
    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] max_reg, max_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             ovf_reg, ovf_next;
    logic             fwd_reg;
    entry_t           fwd_data_reg;
    entry_t           entry0_reg;

    logic             start;
    logic             in_range;
    logic             apply;
    logic [CNT_W-1:0] total_eff;
    logic [CNT_W-1:0] ptr_eff;
    logic [CNT_W-1:0] total_new;
    logic [CNT_W-1:0] ptr_new;
    logic             differs;
    logic             match;
    logic             do_write;
    logic             ovf_new;
    entry_t           head;
    entry_t           entry;
    logic [7:0]       out_byte;

    assign head  = fwd_reg ? fwd_data_reg : rd_data;
    assign apply = (item.action == ACT_APPLY);

    always_comb
    begin
        start     = (pos_reg == '0);
        in_range  = (pos_reg < POS_W'(MAX_FRAME_BYTES));
        total_eff = (start && !apply) ? '0 : total_reg;
        ptr_eff   = (start && apply) ? '0 : ptr_reg;
        entry     = start ? entry0_reg : head;
        ovf_new   = (start ? 1'b0 : ovf_reg) | ~in_range;
        do_write  = 1'b0;
        match     = 1'b0;
        differs   = 1'b0;
        total_new = total_eff;
        ptr_new   = ptr_reg;
        out_byte  = item.base_byte;
        unique case (item.action)
            ACT_ENCODE:
            begin
                out_byte = item.new_byte;
                differs  = (item.base_byte != item.new_byte);
                if (differs && in_range)
                begin
                    if (total_eff < CNT_W'(MAX_DIFFS))
                    begin
                        do_write  = 1'b1;
                        total_new = total_eff + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_new = 1'b1;
                    end
                end
            end
            ACT_APPLY:
            begin
                match = in_range && (ptr_eff < total_eff) &&
                        (ptr_eff < CNT_W'(MAX_DIFFS)) &&
                        (entry.position == POS_STORE_W'(pos_reg));
                differs  = match;
                out_byte = match ? entry.value : item.base_byte;
                ptr_new  = ptr_eff + CNT_W'(match);
            end
            default:
            begin
                out_byte = item.base_byte;
            end
        endcase
    end

    always_comb
    begin
        total_next = total_reg;
        max_next   = max_reg;
        ptr_next   = ptr_reg;
        pos_next   = pos_reg;
        ovf_next   = ovf_reg;
        if (fire)
        begin
            total_next = total_new;
            ptr_next   = ptr_new;
            ovf_next   = ovf_new;
            if (!apply && item.frame_end && (total_new > max_reg))
            begin
                max_next = total_new;
            end
            if (item.frame_end)
            begin
                pos_next = '0;
            end
            else if (in_range)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    assign wr_en            = fire && do_write;
    assign wr_idx           = total_eff[IDX_W-1:0];
    assign wr_data.position = POS_STORE_W'(pos_reg);
    assign wr_data.value    = item.new_byte;
    assign rd_idx           = ptr_next[IDX_W-1:0];

    assign result.out_byte       = out_byte;
    assign result.byte_differs   = differs;
    assign result.diff_count     = COUNT_OUT_W'(total_new);
    assign result.max_diff_count = COUNT_OUT_W'(max_next);
    assign result.overflow       = ovf_new;
    assign result.frame_done     = item.frame_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            max_reg   <= '0;
            ptr_reg   <= '0;
            pos_reg   <= '0;
            ovf_reg   <= 1'b0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            total_reg <= total_next;
            max_reg   <= max_next;
            ptr_reg   <= ptr_next;
            pos_reg   <= pos_next;
            ovf_reg   <= ovf_next;
            fwd_reg   <= wr_en && (wr_idx == rd_idx);
        end
    end

    // bypass of a write that lands on the entry being prefetched, and held copy of entry zero
    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wr_data;
        if (wr_en && (wr_idx == '0))
        begin
            entry0_reg <= wr_data;
        end
    end

endmodule

@@ rtl/sbd_out_stage.sv @@
// sparse byte diff codec: output register between core and result channel
// depends on sbd_pkg
module sbd_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  sbd_pkg::result_t   data,
    output logic               free,
    output logic               result_valid,
    input  logic               result_ready,
    output sbd_pkg::result_t   result
);
    import sbd_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign free = !valid_reg || result_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

@@ rtl/sparse_byte_diff_codec_unit.sv @@
// sparse byte diff codec: top level, ties core, diff table memory and output register
// depends on sbd_pkg, sbd_diff_mem, sbd_core, sbd_out_stage
//
// Takes one byte transaction per clock, unless held off as below, and presents its
// result in the cycle after acceptance; a new transaction is taken in any cycle in which
// the output register is empty or its result is being taken, so a waiting result holds off
// the input. The rate is set by the single read port of the diff table: the entry at the
// apply pointer is prefetched every cycle, with a write bypass and a held copy of entry
// zero for frame starts, so apply-mode matches never stall. Encode mode stores each
// differing in-range byte, while the table has room, as a position and value pair; apply
// mode walks the table in order and substitutes matching bytes. Table contents need no
// clearing after reset, so the block is ready immediately.
module sparse_byte_diff_codec_unit #(
    parameter int MAX_DIFFS       = sbd_pkg::MAX_DIFFS_DEF,
    parameter int MAX_FRAME_BYTES = sbd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  sbd_pkg::item_t     item,
    output logic               result_valid,
    input  logic               result_ready,
    output sbd_pkg::result_t   result
);
    import sbd_pkg::*;

    localparam int IDX_W = (MAX_DIFFS > 1) ? $clog2(MAX_DIFFS) : 1;

    logic             fire;
    result_t          core_result;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_data;
    logic [IDX_W-1:0] rd_idx;
    entry_t           rd_data;

    assign fire = item_valid && item_ready;

    sbd_core #(
        .MAX_DIFFS       (MAX_DIFFS),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .IDX_W           (IDX_W)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (item),
        .result  (core_result),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    sbd_diff_mem #(
        .DEPTH (MAX_DIFFS),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    sbd_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (fire),
        .data         (core_result),
        .free         (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
